/* src/greedy_word_wrap_assert.svh */
// Assertion macros used by the greedy word wrap top level.
`ifndef GREEDY_WORD_WRAP_ASSERT_SVH
`define GREEDY_WORD_WRAP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define GWW_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("greedy_word_wrap: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define GWW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("greedy_word_wrap: next-cycle check failed");

`endif

/* src/gww_pkg.sv */
// Types and constants shared by the greedy word wrap modules.
`timescale 1ns / 1ps
`default_nettype none

package gww_pkg;

  localparam int GLYPH_W = 16;
  localparam int LEN_W   = 6;

  // Configuration register indexes
  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_SEPARATOR  = 1'b1;

  localparam logic [LEN_W-1:0]   LINE_WIDTH_RST = 6'd32;
  localparam logic [GLYPH_W-1:0] SEPARATOR_RST  = 16'd32;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BUSY = 3'b010,
    ST_WORD = 3'b100
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;     // take the input transaction and plan its results
    logic emit_pre;   // load a break that closes the pending line
    logic emit_sep;   // load the separator glyph
    logic rd_word;    // read the next held glyph from the word buffer
    logic emit_word;  // load the glyph just read
    logic emit_post;  // load the closing break
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pre;        // leading break pending
    logic sep;        // separator pending
    logic word;       // word glyphs remain
    logic word_last;  // exactly one word glyph remains
    logic post;       // closing break pending
    logic out_free;   // output register can load this cycle
  } status_t;

endpackage

`default_nettype wire

/* src/greedy_word_wrap.sv */
// Top level of the streaming greedy word wrap block.
//
//  channel  signals                              payload
//  s        s_tvalid s_tready s_tdata s_tlast    tdata: glyph_code; tlast: end_of_text
//  m        m_tvalid m_tready m_tdata m_tuser    tdata: out_glyph; tuser: is_break;
//           m_tlast                              tlast: last_of_run
//  cfg      cfg_valid cfg_ready cfg_index        index 0: line_width, 1: separator_code
//           cfg_data
//
// An input glyph is taken in the idle state; the busy state then starts on its results,
// or returns to idle when the glyph causes none.
// Each break or separator result is loaded from the busy state; each word glyph is
// first read from the word buffer (a registered read) and then loaded from the word state.
// Reset (rst, synchronous) clears the line and word, width 32, separator 32.
// A stalled output holds the sequencer; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

`include "greedy_word_wrap_assert.svh"

module greedy_word_wrap #(
  parameter int MAX_LINE = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input stream
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [gww_pkg::GLYPH_W-1:0] s_tdata,   // [15:0] glyph_code
  input  wire logic                        s_tlast,
  // output stream
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [gww_pkg::GLYPH_W-1:0]      m_tdata,   // [15:0] out_glyph
  output logic                             m_tuser,   // [0] is_break
  output logic                             m_tlast,
  // configuration writes
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_index,
  input  wire logic [gww_pkg::GLYPH_W-1:0] cfg_data
);

  gww_pkg::cmd_t    cmd;
  gww_pkg::status_t st;
  logic [3:0]       loads;
  logic             any_load;
  logic             any_plan;

  gww_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  gww_dp #(
    .MAX_LINE (MAX_LINE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .glyph     (s_tdata),
    .eot       (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .st        (st)
  );

  // Collect output loads and pending plan for the checks
  assign loads    = {cmd.emit_pre, cmd.emit_sep, cmd.emit_word, cmd.emit_post};
  assign any_load = |loads;
  assign any_plan = st.pre | st.sep | st.word | st.post;

  // Ready for a new glyph only with no results of the previous one pending
  `GWW_ASSERT_SAME(a_idle_no_plan, clk, rst, s_tready, !any_plan)
  // At most one output load per cycle
  `GWW_ASSERT_SAME(a_one_load, clk, rst, 1'b1, $onehot0(loads))
  // Never overwrite an output transaction that has not been taken
  `GWW_ASSERT_SAME(a_load_free, clk, rst, any_load, st.out_free)
  // A word read is always followed by a pending glyph load
  `GWW_ASSERT_NEXT(a_read_then_word, clk, rst, cmd.rd_word, st.word)

endmodule

`default_nettype wire

/* src/gww_ctrl.sv */
// Controller state machine that sequences the results of one glyph.
`timescale 1ns / 1ps
`default_nettype none

module gww_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire gww_pkg::status_t st,
  output gww_pkg::cmd_t        cmd
);

  gww_pkg::state_t state, state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gww_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pick one action per cycle, waiting while the output is not free: leading break, separator, word, closing break
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      gww_pkg::ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          state_next = gww_pkg::ST_BUSY;
        end
      end
      gww_pkg::ST_BUSY: begin
        if (st.pre) begin
          if (st.out_free) begin
            cmd.emit_pre = 1'b1;
            if (!st.sep && !st.word && !st.post) begin
              state_next = gww_pkg::ST_IDLE;
            end
          end
        end else if (st.sep) begin
          if (st.out_free) begin
            cmd.emit_sep = 1'b1;
            if (!st.word && !st.post) begin
              state_next = gww_pkg::ST_IDLE;
            end
          end
        end else if (st.word) begin
          cmd.rd_word = 1'b1;
          state_next  = gww_pkg::ST_WORD;
        end else if (st.post) begin
          if (st.out_free) begin
            cmd.emit_post = 1'b1;
            state_next    = gww_pkg::ST_IDLE;
          end
        end else begin
          state_next = gww_pkg::ST_IDLE;
        end
      end
      gww_pkg::ST_WORD: begin
        if (st.out_free) begin
          cmd.emit_word = 1'b1;
          if (st.word_last && !st.post) begin
            state_next = gww_pkg::ST_IDLE;
          end else begin
            state_next = gww_pkg::ST_BUSY;
          end
        end
      end
      default: begin
        state_next = gww_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/gww_dp.sv */
// Datapath: configuration, word buffer, line bookkeeping and output register.
`timescale 1ns / 1ps
`default_nettype none

module gww_dp #(
  parameter int MAX_LINE = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [gww_pkg::GLYPH_W-1:0]   cfg_data,
  // input payload
  input  wire logic [gww_pkg::GLYPH_W-1:0]   glyph,
  input  wire logic                          eot,
  // output channel
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [gww_pkg::GLYPH_W-1:0]        m_tdata,
  output logic                               m_tuser,
  output logic                               m_tlast,
  // control
  input  wire gww_pkg::cmd_t                 cmd,
  output gww_pkg::status_t                   st
);

  localparam int LW  = gww_pkg::LEN_W;
  localparam int GW  = gww_pkg::GLYPH_W;
  localparam int LIM = (MAX_LINE < 32) ? MAX_LINE : 32;
  localparam int AW  = $clog2(MAX_LINE);

  logic [LW-1:0] line_width;
  logic [GW-1:0] separator_code;
  logic [GW-1:0] word_store [MAX_LINE];
  logic [LW-1:0] wl, ll;
  logic          pre, sep, post;
  logic [LW-1:0] rem;
  logic [AW-1:0] rd_idx;
  logic [GW-1:0] rdata;

  logic [LW-1:0] w, wl_c, wl1, ll_base, ll_p;
  logic [LW:0]   need;
  logic          is_glyph, chunk, has_word, p_brk, p_sep;
  logic          load;
  logic [GW-1:0] load_data;
  logic          load_user, load_last;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width     <= gww_pkg::LINE_WIDTH_RST;
      separator_code <= gww_pkg::SEPARATOR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gww_pkg::REG_LINE_WIDTH: line_width     <= cfg_data[LW-1:0];
        gww_pkg::REG_SEPARATOR:  separator_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate the width to 1..LIM and plan the results of the input glyph
  always_comb begin
    if (line_width == '0) begin
      w = LW'(1);
    end else if (line_width > LW'(LIM)) begin
      w = LW'(LIM);
    end else begin
      w = line_width;
    end
    wl_c     = (wl > w - LW'(1)) ? w - LW'(1) : wl;
    is_glyph = (glyph != separator_code);
    wl1      = is_glyph ? wl_c + LW'(1) : wl_c;
    chunk    = is_glyph && (wl1 >= w);
    has_word = (wl1 != '0);
    need     = {1'b0, ll} + {1'b0, wl1} + (LW+1)'(1);
    p_brk    = has_word && (ll != '0) && (need > {1'b0, w});
    p_sep    = has_word && (ll != '0) && !p_brk;
    ll_base  = p_brk ? '0 : ll;
    ll_p     = has_word ? ll_base + {{(LW-1){1'b0}}, p_sep} + wl1 : ll;
  end

  // Store non-separator glyphs in the word buffer
  always_ff @(posedge clk) begin
    if (cmd.accept && is_glyph) begin
      word_store[wl_c[AW-1:0]] <= glyph;
    end
  end

  // Read the next held glyph
  always_ff @(posedge clk) begin
    if (cmd.rd_word) begin
      rdata <= word_store[rd_idx];
    end
  end

  // Update line state and the pending result plan
  always_ff @(posedge clk) begin
    if (rst) begin
      wl   <= '0;
      ll   <= '0;
      pre  <= 1'b0;
      sep  <= 1'b0;
      post <= 1'b0;
      rem  <= '0;
    end else begin
      if (cmd.accept) begin
        rd_idx <= '0;
        if (chunk) begin
          pre  <= (ll != '0);
          sep  <= 1'b0;
          rem  <= wl1;
          post <= 1'b1;
          wl   <= '0;
          ll   <= '0;
        end else if (is_glyph && !eot) begin
          pre  <= 1'b0;
          sep  <= 1'b0;
          rem  <= '0;
          post <= 1'b0;
          wl   <= wl1;
        end else begin
          pre  <= p_brk;
          sep  <= p_sep;
          rem  <= wl1;
          post <= eot && (ll_p != '0);
          wl   <= '0;
          ll   <= eot ? '0 : ll_p;
        end
      end
      if (cmd.emit_pre) begin
        pre <= 1'b0;
      end
      if (cmd.emit_sep) begin
        sep <= 1'b0;
      end
      if (cmd.emit_word) begin
        rem    <= rem - LW'(1);
        rd_idx <= rd_idx + AW'(1);
      end
      if (cmd.emit_post) begin
        post <= 1'b0;
      end
    end
  end

  // Select the item to load into the output register
  always_comb begin
    load      = cmd.emit_pre | cmd.emit_sep | cmd.emit_word | cmd.emit_post;
    load_data = '0;
    load_user = 1'b0;
    load_last = 1'b0;
    if (cmd.emit_pre) begin
      load_user = 1'b1;
      load_last = !sep && (rem == '0) && !post;
    end else if (cmd.emit_sep) begin
      load_data = separator_code;
      load_last = (rem == '0) && !post;
    end else if (cmd.emit_word) begin
      load_data = rdata;
      load_last = (rem == LW'(1)) && !post;
    end else if (cmd.emit_post) begin
      load_user = 1'b1;
      load_last = 1'b1;
    end
  end

  // Hold the output transaction until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= load_data;
      m_tuser <= load_user;
      m_tlast <= load_last;
    end
  end

  assign st.pre       = pre;
  assign st.sep       = sep;
  assign st.word      = (rem != '0);
  assign st.word_last = (rem == LW'(1));
  assign st.post      = post;
  assign st.out_free  = !m_tvalid || m_tready;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the streaming greedy word wrap block.
`timescale 1ns / 1ps

module testbench;

  localparam int GW            = gww_pkg::GLYPH_W;
  localparam int LW            = gww_pkg::LEN_W;
  localparam int WIDTH_CAP     = 32;     // effective line width limit (MAX_LINE)
  localparam int SETTLE_CYCLES = 8;      // dispatch and drain slack after the last result
  localparam int RANDOM_ITEMS  = 290;

  typedef struct packed {
    logic [GW-1:0] glyph;
    logic          brk;
    logic          last;
  } layout_item_t;

  typedef enum int {
    RX_ALWAYS,
    RX_CHOPPY,
    RX_BLOCKING
  } rx_mode_t;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          s_tvalid  = 1'b0;
  logic          s_tready;
  logic [GW-1:0] s_tdata   = '0;   // [15:0] glyph_code
  logic          s_tlast   = 1'b0;
  logic          m_tvalid;
  logic          m_tready  = 1'b0;
  logic [GW-1:0] m_tdata;          // [15:0] out_glyph
  logic          m_tuser;          // [0] is_break
  logic          m_tlast;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic          cfg_index = 1'b0;
  logic [GW-1:0] cfg_data  = '0;

  // Line layout predictor state
  logic [LW-1:0] wrap_width;
  logic [GW-1:0] wrap_sep;
  logic [GW-1:0] word_buf [WIDTH_CAP];
  int            word_len;
  int            line_len;
  layout_item_t  layout_q[$];

  int       errors       = 0;
  int       glyphs_sent  = 0;
  int       items_seen   = 0;
  int       breaks_seen  = 0;
  int       settings     = 0;
  int       burst_left   = 0;
  bit       gaps_on      = 1'b1;
  int       stall_left   = 0;
  rx_mode_t rx_mode      = RX_ALWAYS;

  greedy_word_wrap u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Effective width: zero acts as one, anything above the cap acts as the cap
  function automatic int line_limit();
    if (wrap_width == '0) return 1;
    if (int'(wrap_width) > WIDTH_CAP) return WIDTH_CAP;
    return int'(wrap_width);
  endfunction

  function automatic layout_item_t layout_item(logic [GW-1:0] glyph, logic brk);
    layout_item_t r;
    r.glyph = glyph;
    r.brk   = brk;
    r.last  = 1'b0;
    return r;
  endfunction

  // Append one predicted result at the tail of the queue
  task automatic queue_result(input layout_item_t item);
    layout_q.insert(layout_q.size(), item);
  endtask

  task automatic push_word();
    for (int i = 0; i < word_len; i++) queue_result(layout_item(word_buf[i], 1'b0));
  endtask

  // Predict the results of one accepted glyph and queue them
  task automatic wrap_glyph(input logic [GW-1:0] glyph, input logic eot);
    int           w;
    int           n0;
    layout_item_t tail;
    w  = line_limit();
    n0 = layout_q.size();
    if (word_len > w - 1) word_len = w - 1;
    if (glyph != wrap_sep) begin
      word_buf[word_len] = glyph;
      word_len++;
      // full-width chunk: close the pending line, place the chunk, break
      if (word_len >= w) begin
        if (line_len > 0) queue_result(layout_item('0, 1'b1));
        push_word();
        queue_result(layout_item('0, 1'b1));
        word_len = 0;
        line_len = 0;
      end
    end
    if (glyph == wrap_sep || eot) begin
      if (word_len > 0) begin
        if (line_len > 0 && line_len + word_len + 1 > w) begin
          queue_result(layout_item('0, 1'b1));
          line_len = 0;
        end
        if (line_len > 0) begin
          queue_result(layout_item(wrap_sep, 1'b0));
          line_len++;
        end
        push_word();
        line_len += word_len;
        word_len = 0;
      end
      if (eot) begin
        if (line_len > 0) queue_result(layout_item('0, 1'b1));
        line_len = 0;
        word_len = 0;
      end
    end
    if (layout_q.size() > n0) begin
      tail      = layout_q.pop_back();
      tail.last = 1'b1;
      queue_result(tail);
    end
  endtask

  // Send one glyph; bursts of random length with random gaps in between when gaps are on
  task automatic send_glyph(input logic [GW-1:0] glyph, input logic eot);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = gaps_on ? $urandom_range(0, 6) : 0;
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= glyph;
    s_tlast  <= eot;
    do @(posedge clk); while (!s_tready);
    wrap_glyph(glyph, eot);
    glyphs_sent++;
  endtask

  // Drop valid and wait until every predicted result has arrived
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (layout_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [GW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == gww_pkg::REG_LINE_WIDTH) wrap_width = data[LW-1:0];
    else wrap_sep = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Receiver stall pattern
  always @(negedge clk) begin
    case (rx_mode)
      RX_ALWAYS: m_tready <= 1'b1;
      RX_CHOPPY: m_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          m_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          stall_left = $urandom_range(3, 16);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    endcase
  end

  // Compare each output transaction with the oldest prediction
  always @(posedge clk) begin : check_output
    layout_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (layout_q.size() == 0) begin
        $error("unexpected result: out_glyph %h is_break %b last_of_run %b",
               m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        want = layout_q.pop_front();
        if (m_tdata !== want.glyph) begin
          $error("out_glyph: expected %h, actual %h", want.glyph, m_tdata);
          errors++;
        end
        if (m_tuser !== want.brk) begin
          $error("is_break: expected %b, actual %b", want.brk, m_tuser);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last_of_run: expected %b, actual %b", want.last, m_tlast);
          errors++;
        end
        items_seen++;
        if (want.brk) breaks_seen++;
      end
    end
  end

  // Reset settings: extreme glyph codes, collapsed separators, separator with end mark
  task automatic test_default_setting();
    send_glyph(16'hFFFF, 1'b0);
    send_glyph(16'h0000, 1'b0);
    send_glyph(wrap_sep, 1'b0);
    send_glyph(wrap_sep, 1'b0);
    send_glyph(16'h0041, 1'b0);
    send_glyph(wrap_sep, 1'b1);
    wait_drained();
  endtask

  // Narrow lines: word pushed to the next line, chunk that closes a pending line
  task automatic test_narrow_lines();
    write_reg(gww_pkg::REG_LINE_WIDTH, 16'd4);
    send_glyph(16'h0061, 1'b0);
    send_glyph(wrap_sep, 1'b0);
    send_glyph(16'h0062, 1'b0);
    send_glyph(16'h0063, 1'b0);
    send_glyph(16'h0064, 1'b1);
    send_glyph(16'h0078, 1'b0);
    send_glyph(wrap_sep, 1'b0);
    send_glyph(16'h0070, 1'b0);
    send_glyph(16'h0071, 1'b0);
    send_glyph(16'h0072, 1'b0);
    send_glyph(16'h0073, 1'b1);
    wait_drained();
  endtask

  // Width zero acts as one, width above the cap acts as the cap
  task automatic test_width_limits();
    write_reg(gww_pkg::REG_LINE_WIDTH, 16'hFFC0);
    send_glyph(16'h1234, 1'b0);
    send_glyph(wrap_sep, 1'b1);
    wait_drained();
    write_reg(gww_pkg::REG_LINE_WIDTH, 16'hFFFF);
    write_reg(gww_pkg::REG_SEPARATOR, 16'hFFFF);
    send_glyph(16'h0020, 1'b0);
    send_glyph(16'hFFFF, 1'b1);
    wait_drained();
  endtask

  // Width lowered while a word is held: excess glyphs are dropped
  task automatic test_width_lowered();
    write_reg(gww_pkg::REG_SEPARATOR, 16'h0020);
    write_reg(gww_pkg::REG_LINE_WIDTH, 16'd8);
    send_glyph(16'h0061, 1'b0);
    send_glyph(16'h0062, 1'b0);
    send_glyph(16'h0063, 1'b0);
    send_glyph(16'h0064, 1'b0);
    wait_drained();
    write_reg(gww_pkg::REG_LINE_WIDTH, 16'd3);
    send_glyph(16'h0065, 1'b0);
    send_glyph(wrap_sep, 1'b1);
    wait_drained();
  endtask

  function automatic logic [GW-1:0] word_glyph();
    logic [GW-1:0] g;
    do g = GW'($urandom); while (g == wrap_sep);
    return g;
  endfunction

  // One text of random words; ends with an end mark on a glyph or a separator
  task automatic send_text();
    int   w;
    int   words;
    int   len;
    int   seps;
    int   pick;
    logic end_on_sep;
    logic last_word;
    w          = line_limit();
    words      = $urandom_range(1, 6);
    end_on_sep = 1'($urandom_range(0, 1));
    for (int k = 0; k < words; k++) begin
      last_word = (k == words - 1);
      pick      = $urandom_range(0, 19);
      if (pick < 15) len = $urandom_range(1, (w > 2) ? w / 2 : 1);
      else if (pick < 19) len = $urandom_range(1, w);
      else len = $urandom_range(w, 2 * w + 1);
      for (int j = 0; j < len; j++) begin
        // occasional noise glyph that may hit the separator
        if ($urandom_range(0, 29) == 0) send_glyph(GW'($urandom), 1'b0);
        else send_glyph(word_glyph(), last_word && !end_on_sep && j == len - 1);
      end
      if (!last_word || end_on_sep) begin
        seps = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
        for (int j = 0; j < seps; j++) send_glyph(wrap_sep, last_word && j == seps - 1);
      end
    end
  endtask

  // Random texts over a series of width, separator and flow-control settings
  task automatic test_random_text();
    int            stop_at;
    logic [GW-1:0] data;
    stop_at = glyphs_sent + RANDOM_ITEMS;
    while (glyphs_sent < stop_at) begin
      data = GW'($urandom);
      case ($urandom_range(0, 5))
        0: data[LW-1:0] = LW'($urandom_range(0, 1));
        1: data[LW-1:0] = 6'd2;
        2: data[LW-1:0] = LW'($urandom_range(WIDTH_CAP, 63));
        default: data[LW-1:0] = LW'($urandom_range(3, 12));
      endcase
      write_reg(gww_pkg::REG_LINE_WIDTH, data);
      write_reg(gww_pkg::REG_SEPARATOR,
                ($urandom_range(0, 1) != 0) ? 16'h0020 : GW'($urandom));
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 4)) send_text();
      wait_drained();
    end
  endtask

  initial begin
    wrap_width = gww_pkg::LINE_WIDTH_RST;
    wrap_sep   = gww_pkg::SEPARATOR_RST;
    word_len   = 0;
    line_len   = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_setting();
    rx_mode = RX_CHOPPY;
    test_narrow_lines();
    rx_mode = RX_BLOCKING;
    test_width_limits();
    test_width_lowered();
    test_random_text();

    $display("Covered %0d glyphs under %0d register writes; %0d results checked, %0d breaks.",
             glyphs_sent, settings, items_seen, breaks_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hold a hard limit on run time
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* greedy_word_wrap.f */
+incdir+src
src/gww_pkg.sv
src/gww_ctrl.sv
src/gww_dp.sv
src/greedy_word_wrap.sv
tb/sv/testbench.sv
